### rtl/rgbc3_pkg.sv
`default_nettype none

package rgbc3_pkg;

    localparam int MAX_COLS    = 1024;
    localparam int KERNEL_SIZE = 3;
    localparam int NUM_CH      = 3;
    localparam int CH_W        = 8;
    localparam int PIX_W       = NUM_CH * CH_W;
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int FROWS_W     = 16;
    localparam int FCOLS_W     = 11;
    localparam int ROW_W       = FROWS_W + 1;
    localparam int CNT_W       = (COL_W + 1 > FCOLS_W) ? COL_W + 1 : FCOLS_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = KERNEL_SIZE * CH_W;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MIDDLE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS    = CFG_IDX_W'(4);

    localparam logic [CFG_DATA_W-1:0] KERNEL_TOP_RST    = CFG_DATA_W'(0);
    localparam logic [CFG_DATA_W-1:0] KERNEL_MIDDLE_RST = CFG_DATA_W'(256);
    localparam logic [CFG_DATA_W-1:0] KERNEL_BOTTOM_RST = CFG_DATA_W'(0);
    localparam logic [FROWS_W-1:0]    FRAME_ROWS_RST    = FROWS_W'(480);
    localparam logic [FCOLS_W-1:0]    FRAME_COLS_RST    = FCOLS_W'(640);

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
        logic            flush;
    } pix_in_t;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic            last_of_frame;
    } pix_out_t;

endpackage

`default_nettype wire

### rtl/rgb_conv3x3_filter_top.sv
`default_nettype none
// Streaming 3x3 convolution on RGB pixels, one pixel per clock while the receiver does not stall.
// Input channel (s_valid/s_ready/s_data): pixels in raster order; after the
// last pixel of a frame send frame_cols+1 items with flush set to drain it.
// Result channel (m_valid/m_ready/m_data): one filtered pixel per input item
// from the second item of the second row on; the result for a pixel leaves
// with the item frame_cols+1 positions later. last_of_frame marks the final
// filtered pixel of a frame.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always
// ready; write kernel rows and frame geometry only while the block is idle.
// A result passes the input register, window register, product register and
// result register before it is visible on m_valid after the transfer of the
// item that releases it. Throughput: one item per cycle while the receiver does
// not stall; the line memory is read at accept time and written when the item leaves the input register.
// Reset clears positions, window and pipeline valids and loads the configuration defaults; the
// line memory is not cleared (no pass, no wait after reset).
// When the receiver stalls, the four stages fill first; input transfers
// continue as long as any stage holds a bubble.
module rgb_conv3x3_filter_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rgbc3_pkg::pix_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rgbc3_pkg::pix_out_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rgbc3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rgbc3_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import rgbc3_pkg::*;

    typedef logic [PIX_W-1:0] rgb_t;
    typedef rgb_t [KERNEL_SIZE-1:0] column_t;

    typedef struct packed {
        logic bot_en;
        logic mid_en;
        logic top_en;
        logic col_zero;
        logic emit;
        logic last;
    } item_ctl_t;

    logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][CH_W-1:0] kernel_reg;
    logic [FROWS_W-1:0] frame_rows_reg;
    logic [FCOLS_W-1:0] frame_cols_reg;

    logic [ROW_W-1:0] row_pos_reg, row_pos_next;
    logic [COL_W-1:0] col_pos_reg, col_pos_next;

    logic [ROW_W-1:0] rows_eff, rows_p1, cur_row;
    logic [CNT_W-1:0] fcols, cols_eff, col_inc;
    logic [COL_W-1:0] cur_col;
    logic             wrap, accept;
    item_ctl_t        cur_ctl;

    logic             s1_valid_reg;
    rgb_t             s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;
    item_ctl_t        s1_ctl_reg;
    logic             s1_go;

    logic [2*PIX_W-1:0] line_mem [MAX_COLS];
    logic [2*PIX_W-1:0] line_rd_reg, fwd_data_reg, line_cur, wr_data;
    logic               fwd_hit_reg;
    rgb_t               upper, lower, bot, mid, top;
    column_t            new_col;
    column_t [1:0]      win_reg;
    column_t [KERNEL_SIZE-1:0] conv_win;

    logic                      w_valid_reg, w_last_reg, w_free;
    column_t [KERNEL_SIZE-1:0] w_win_reg;

    logic [NUM_CH-1:0][KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][CH_W-1:0] prod, p_prod_reg;
    logic             p_valid_reg, p_last_reg, p_free;

    logic [NUM_CH-1:0][CH_W-1:0] sums;
    logic       m_valid_reg, out_free;
    pix_out_t   m_data_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_reg     <= {KERNEL_BOTTOM_RST, KERNEL_MIDDLE_RST, KERNEL_TOP_RST};
            frame_rows_reg <= FRAME_ROWS_RST;
            frame_cols_reg <= FRAME_COLS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_KERNEL_TOP:    kernel_reg[0]  <= cfg_data;
                REG_KERNEL_MIDDLE: kernel_reg[1]  <= cfg_data;
                REG_KERNEL_BOTTOM: kernel_reg[2]  <= cfg_data;
                REG_FRAME_ROWS:    frame_rows_reg <= cfg_data[FROWS_W-1:0];
                REG_FRAME_COLS:    frame_cols_reg <= cfg_data[FCOLS_W-1:0];
                default: ;
            endcase
        end
    end

    // position of the incoming item and its window controls
    always_comb begin
        rows_eff = (frame_rows_reg == '0) ? ROW_W'(1) : ROW_W'(frame_rows_reg);
        rows_p1  = rows_eff + ROW_W'(1);
        fcols    = CNT_W'(frame_cols_reg);
        if (fcols == '0) begin
            cols_eff = CNT_W'(1);
        end else if (fcols > CNT_W'(MAX_COLS)) begin
            cols_eff = CNT_W'(MAX_COLS);
        end else begin
            cols_eff = fcols;
        end
        wrap    = CNT_W'(col_pos_reg) >= cols_eff;
        cur_col = wrap ? '0 : col_pos_reg;
        cur_row = wrap ? row_pos_reg + ROW_W'(1) : row_pos_reg;
        col_inc = CNT_W'(cur_col) + CNT_W'(1);

        cur_ctl.col_zero = (cur_col == '0);
        cur_ctl.bot_en   = (cur_row < rows_eff) && !s_data.flush;
        cur_ctl.mid_en   = (cur_row >= ROW_W'(1)) && (cur_row <= rows_eff);
        cur_ctl.top_en   = (cur_row >= ROW_W'(2)) && (cur_row <= rows_p1);
        cur_ctl.emit     = cur_ctl.col_zero ? cur_ctl.top_en : cur_ctl.mid_en;
        cur_ctl.last     = cur_ctl.col_zero && (cur_row == rows_p1);

        if (cur_ctl.col_zero && cur_row >= rows_p1) begin
            row_pos_next = '0;
            col_pos_next = '0;
        end else if (col_inc >= cols_eff) begin
            row_pos_next = cur_row + ROW_W'(1);
            col_pos_next = '0;
        end else begin
            row_pos_next = cur_row;
            col_pos_next = col_inc[COL_W-1:0];
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign p_free   = !p_valid_reg || out_free;
    assign w_free   = !w_valid_reg || p_free;
    assign s_ready  = !s1_valid_reg || w_free;
    assign s1_go    = s1_valid_reg && w_free;
    assign accept   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_pos_reg  <= '0;
            col_pos_reg  <= '0;
            s1_valid_reg <= 1'b0;
            win_reg      <= '0;
            w_valid_reg  <= 1'b0;
            p_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                row_pos_reg <= row_pos_next;
                col_pos_reg <= col_pos_next;
            end
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s1_go) begin
                win_reg[0] <= s1_ctl_reg.col_zero ? column_t'('0) : win_reg[1];
                win_reg[1] <= new_col;
            end
            if (w_free) begin
                w_valid_reg <= s1_go && s1_ctl_reg.emit;
            end
            if (p_free) begin
                p_valid_reg <= w_valid_reg;
            end
            if (out_free) begin
                m_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg   <= {s_data.blue_in, s_data.green_in, s_data.red_in};
            s1_col_reg   <= cur_col;
            s1_ctl_reg   <= cur_ctl;
            fwd_hit_reg  <= s1_go && (s1_col_reg == cur_col);
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            line_rd_reg <= line_mem[cur_col];
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go) begin
            line_mem[s1_col_reg] <= wr_data;
        end
    end

    // new window column and the window that feeds the multipliers
    always_comb begin
        line_cur   = fwd_hit_reg ? fwd_data_reg : line_rd_reg;
        upper      = line_cur[2*PIX_W-1:PIX_W];
        lower      = line_cur[PIX_W-1:0];
        bot        = s1_ctl_reg.bot_en ? s1_pix_reg : '0;
        mid        = s1_ctl_reg.mid_en ? lower : '0;
        top        = s1_ctl_reg.top_en ? upper : '0;
        wr_data    = {lower, bot};
        new_col[0] = top;
        new_col[1] = mid;
        new_col[2] = bot;
        conv_win[0] = win_reg[0];
        conv_win[1] = win_reg[1];
        conv_win[2] = s1_ctl_reg.col_zero ? column_t'('0) : new_col;
    end

    always_ff @(posedge aclk) begin
        if (w_free) begin
            w_win_reg  <= conv_win;
            w_last_reg <= s1_ctl_reg.last;
        end
    end

    // kernel (x,y) meets the pixel at row 2-x, column 2-y of the window
    always_comb begin
        logic [2*CH_W-1:0] full;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            for (int x = 0; x < KERNEL_SIZE; x++) begin
                for (int y = 0; y < KERNEL_SIZE; y++) begin
                    full = w_win_reg[KERNEL_SIZE-1-y][KERNEL_SIZE-1-x][ch*CH_W +: CH_W]
                           * kernel_reg[x][y];
                    prod[ch][x][y] = full[CH_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p_free) begin
            p_prod_reg <= prod;
            p_last_reg <= w_last_reg;
        end
    end

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            sums[ch] = '0;
            for (int x = 0; x < KERNEL_SIZE; x++) begin
                for (int y = 0; y < KERNEL_SIZE; y++) begin
                    sums[ch] = sums[ch] + p_prod_reg[ch][x][y];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_data_reg.red_out       <= sums[0];
            m_data_reg.green_out     <= sums[1];
            m_data_reg.blue_out      <= sums[2];
            m_data_reg.last_of_frame <= p_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

### rtl/rgbc3_checker.sv
`default_nettype none

module rgbc3_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input rgbc3_pkg::pix_out_t m_data
);
    import rgbc3_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no result pending");

    a_pipe_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $past(aresetn, 1) && $past(aresetn, 2) &&
                    $past(aresetn, 3) && $past(aresetn, 4))
        else $error("result earlier than pipeline depth after reset");

    logic unused_in;
    assign unused_in = s_valid;

endmodule

bind rgb_conv3x3_filter_top rgbc3_checker u_rgbc3_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
